/* hw/rtl/bwvr_pkg.sv */
`timescale 1ns / 1ps

package bwvr_pkg;

    // port widths
    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 48;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 1'b1;

    localparam logic [15:0] TIMEOUT_RST = 16'd500;

    // item kinds carried in tuser
    localparam logic MODE_CMD  = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // queue between front and back, power of two
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_DEPTH       = 24;
    localparam int ATAN_IDX_W       = 5;

    // datapath widths
    localparam int XY_W   = 34;
    localparam int Z_W    = 33;
    localparam int PROD_W = 51;
    localparam int ACC_W  = 68;

    // gain correction 0x9B74EDA8 / 2^32, split into halves
    localparam logic [15:0] GAIN_HI = 16'h9B74;
    localparam logic [15:0] GAIN_LO = 16'hEDA8;
    localparam int          OUT_SHIFT = 46;
    localparam logic signed [ACC_W-1:0] OUT_ROUND = ACC_W'(64'sh0000_2000_0000_0000);

    typedef struct packed {
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] rate;
        logic signed [15:0] angle;
        logic               stale;
    } job_t;

    // atan(2^-i) as a 32-bit binary angle
    function automatic logic signed [Z_W-1:0] atan_val(input logic [ATAN_IDX_W-1:0] i);
        logic [31:0] v;
        begin
            case (i)
                5'd0:    v = 32'h20000000;
                5'd1:    v = 32'h12E4051E;
                5'd2:    v = 32'h09FB385B;
                5'd3:    v = 32'h051111D4;
                5'd4:    v = 32'h028B0D43;
                5'd5:    v = 32'h0145D7E1;
                5'd6:    v = 32'h00A2F61E;
                5'd7:    v = 32'h00517C55;
                5'd8:    v = 32'h0028BE53;
                5'd9:    v = 32'h00145F2F;
                5'd10:   v = 32'h000A2F98;
                5'd11:   v = 32'h000517CC;
                5'd12:   v = 32'h00028BE6;
                5'd13:   v = 32'h000145F3;
                5'd14:   v = 32'h0000A2F9;
                5'd15:   v = 32'h0000517D;
                5'd16:   v = 32'h000028BE;
                5'd17:   v = 32'h0000145F;
                5'd18:   v = 32'h00000A30;
                5'd19:   v = 32'h00000518;
                5'd20:   v = 32'h0000028C;
                5'd21:   v = 32'h00000146;
                5'd22:   v = 32'h000000A3;
                5'd23:   v = 32'h00000051;
                default: v = 32'h00000000;
            endcase
            atan_val = $signed({1'b0, v});
        end
    endfunction

endpackage

/* hw/rtl/bwvr_front.sv */
`timescale 1ns / 1ps

module bwvr_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wen,
    input  logic [bwvr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bwvr_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [bwvr_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic                                s_tuser,
    output logic                                job_valid,
    input  logic                                job_ready,
    output bwvr_pkg::job_t                      job
);

    logic [15:0]        timeout_reg;
    logic               enable_reg;
    logic signed [15:0] stored_vx_reg;
    logic signed [15:0] stored_vy_reg;
    logic signed [15:0] stored_rate_reg;
    logic [31:0]        stored_stamp_reg;

    logic               s1_valid_reg;
    logic signed [15:0] s1_vx_reg, s1_vy_reg, s1_rate_reg, s1_head_reg;
    logic [15:0]        s1_period_reg;
    logic               s1_stale_reg;

    logic               s2_valid_reg;
    logic signed [32:0] s2_prod_reg;
    logic signed [15:0] s2_vx_reg, s2_vy_reg, s2_rate_reg, s2_head_reg;
    logic               s2_stale_reg;

    logic [31:0]        time_now;
    logic [31:0]        age;
    logic               stale;
    logic               accept, cmd_take, tick_take, s1_adv, push;
    logic signed [33:0] rnd_sum;
    logic signed [16:0] delta;

    assign time_now  = s_tdata[31:0];
    assign s_tready  = !s1_valid_reg;
    assign accept    = s_tvalid && s_tready;
    assign cmd_take  = accept && (s_tuser == bwvr_pkg::MODE_CMD) && enable_reg;
    assign tick_take = accept && (s_tuser == bwvr_pkg::MODE_TICK);

    // wrapping age against the stored stamp
    assign age   = time_now - stored_stamp_reg;
    assign stale = age > {16'd0, timeout_reg};

    assign push      = s2_valid_reg && job_ready;
    assign s1_adv    = s1_valid_reg && (!s2_valid_reg || push);
    assign job_valid = s2_valid_reg;

    // midpoint correction, half of rate times period, ties upward
    assign rnd_sum = 34'(s2_prod_reg) + 34'sd65536;
    assign delta   = 17'(rnd_sum >>> 17);

    always_comb
    begin
        job.vx    = s2_vx_reg;
        job.vy    = s2_vy_reg;
        job.rate  = s2_rate_reg;
        job.angle = s2_head_reg + delta[15:0];
        job.stale = s2_stale_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= bwvr_pkg::TIMEOUT_RST;
            enable_reg  <= 1'b0;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                bwvr_pkg::REG_TIMEOUT: timeout_reg <= cfg_data;
                bwvr_pkg::REG_ENABLE:  enable_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_vx_reg    <= '0;
            stored_vy_reg    <= '0;
            stored_rate_reg  <= '0;
            stored_stamp_reg <= '0;
        end
        else if (cmd_take)
        begin
            stored_vx_reg    <= s_tdata[47:32];
            stored_vy_reg    <= s_tdata[63:48];
            stored_rate_reg  <= s_tdata[79:64];
            stored_stamp_reg <= time_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (tick_take)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_adv)
                s2_valid_reg <= 1'b1;
            else if (push)
                s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_take)
        begin
            s1_vx_reg     <= stale ? 16'sd0 : stored_vx_reg;
            s1_vy_reg     <= stale ? 16'sd0 : stored_vy_reg;
            s1_rate_reg   <= stale ? 16'sd0 : stored_rate_reg;
            s1_stale_reg  <= stale;
            s1_head_reg   <= s_tdata[95:80];
            s1_period_reg <= s_tdata[111:96];
        end
        if (s1_adv)
        begin
            s2_prod_reg  <= 33'(s1_rate_reg) * $signed({17'd0, s1_period_reg});
            s2_vx_reg    <= s1_vx_reg;
            s2_vy_reg    <= s1_vy_reg;
            s2_rate_reg  <= s1_rate_reg;
            s2_head_reg  <= s1_head_reg;
            s2_stale_reg <= s1_stale_reg;
        end
    end

endmodule

/* hw/rtl/bwvr_queue.sv */
`timescale 1ns / 1ps

module bwvr_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  bwvr_pkg::job_t push_job,
    output logic           pop_valid,
    input  logic           pop,
    output bwvr_pkg::job_t pop_job
);

    localparam int CNT_W = $clog2(bwvr_pkg::QDEPTH + 1);

    bwvr_pkg::job_t                 entry_reg [bwvr_pkg::QDEPTH];
    logic [bwvr_pkg::QPTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]               count_reg;
    logic                           push;

    assign push_ready = count_reg != CNT_W'(bwvr_pkg::QDEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop_job    = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid && !push_ready && !pop |=> count_reg == CNT_W'(bwvr_pkg::QDEPTH))
        else $error("queue lost its full state while a transfer waited");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("queue popped while empty");

endmodule

/* hw/rtl/bwvr_back.sv */
`timescale 1ns / 1ps

module bwvr_back #(
    parameter int CORDIC_STEPS = bwvr_pkg::CORDIC_STEPS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              job_valid,
    output logic                              job_pop,
    input  bwvr_pkg::job_t                    job,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bwvr_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                              m_tuser
);

    localparam int STEP_W = $clog2(CORDIC_STEPS);
    localparam int XY_W   = bwvr_pkg::XY_W;
    localparam int Z_W    = bwvr_pkg::Z_W;
    localparam int PROD_W = bwvr_pkg::PROD_W;
    localparam int ACC_W  = bwvr_pkg::ACC_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_ROT  = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t                   state_reg, state_next;
    logic [STEP_W-1:0]        step_reg;
    logic [1:0]               mstep_reg;
    logic                     axis_reg;

    logic signed [XY_W-1:0]   x_reg, y_reg;
    logic signed [Z_W-1:0]    z_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [15:0]       res_x_reg, res_y_reg, rate_reg;
    logic                     stale_reg;

    logic                     m_tvalid_reg;
    logic [bwvr_pkg::OUT_DATA_W-1:0] m_tdata_reg;
    logic                     m_tuser_reg;

    logic                     fold, last_step, out_load;
    logic signed [XY_W-1:0]   x_in, y_in, dx, dy, mul_a;
    logic signed [15:0]       ang_fold;
    logic signed [Z_W-1:0]    atan_step;
    logic [15:0]              mul_half;
    logic signed [PROD_W-1:0] mul_out;
    logic signed [ACC_W-1:0]  acc_sum, acc_shift;
    logic signed [15:0]       sat_out;

    // beyond a quarter turn: negate the vector and turn the angle by half a turn
    assign fold     = (job.angle > 16'sd16384) || (job.angle < -16'sd16384);
    assign ang_fold = fold ? {~job.angle[15], job.angle[14:0]} : job.angle;
    assign x_in     = XY_W'(job.vx) <<< 14;
    assign y_in     = XY_W'(job.vy) <<< 14;

    assign dx        = y_reg >>> step_reg;
    assign dy        = x_reg >>> step_reg;
    assign atan_step = bwvr_pkg::atan_val(bwvr_pkg::ATAN_IDX_W'(step_reg));
    assign last_step = step_reg == STEP_W'(CORDIC_STEPS - 1);

    // gain correction in two 16-bit halves through one multiplier
    assign mul_a    = axis_reg ? y_reg : x_reg;
    assign mul_half = (mstep_reg == 2'd0) ? bwvr_pkg::GAIN_HI : bwvr_pkg::GAIN_LO;
    assign mul_out  = PROD_W'(mul_a) * PROD_W'($signed({1'b0, mul_half}));

    assign acc_sum   = acc_reg + ACC_W'(prod_reg) + bwvr_pkg::OUT_ROUND;
    assign acc_shift = acc_sum >>> bwvr_pkg::OUT_SHIFT;
    assign sat_out   = ((&acc_shift[ACC_W-1:15]) || !(|acc_shift[ACC_W-1:15]))
                       ? acc_shift[15:0]
                       : (acc_shift[ACC_W-1] ? 16'sh8000 : 16'sh7FFF);

    assign job_pop  = (state_reg == ST_IDLE) && job_valid;
    assign out_load = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (job_valid) state_next = ST_ROT;
            ST_ROT:  if (last_step) state_next = ST_MUL;
            ST_MUL:  if (axis_reg && mstep_reg == 2'd2) state_next = ST_DONE;
            ST_DONE: if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            mstep_reg    <= 2'd0;
            axis_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                begin
                    step_reg  <= '0;
                    mstep_reg <= 2'd0;
                    axis_reg  <= 1'b0;
                end
                ST_ROT:
                    if (!last_step)
                        step_reg <= step_reg + 1'b1;
                ST_MUL:
                begin
                    if (mstep_reg == 2'd2)
                    begin
                        mstep_reg <= 2'd0;
                        axis_reg  <= 1'b1;
                    end
                    else
                        mstep_reg <= mstep_reg + 1'b1;
                end
                default: ;
            endcase
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (job_valid)
                begin
                    x_reg     <= fold ? -x_in : x_in;
                    y_reg     <= fold ? -y_in : y_in;
                    z_reg     <= Z_W'($signed({ang_fold, 16'd0}));
                    rate_reg  <= job.rate;
                    stale_reg <= job.stale;
                end
            ST_ROT:
                if (!z_reg[Z_W-1])
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - atan_step;
                end
                else
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + atan_step;
                end
            ST_MUL:
                case (mstep_reg)
                    2'd0: prod_reg <= mul_out;
                    2'd1:
                    begin
                        acc_reg  <= ACC_W'(prod_reg) <<< 16;
                        prod_reg <= mul_out;
                    end
                    2'd2:
                        if (axis_reg)
                            res_y_reg <= sat_out;
                        else
                            res_x_reg <= sat_out;
                    default: ;
                endcase
            default: ;
        endcase
        if (out_load)
        begin
            m_tdata_reg <= {rate_reg, res_y_reg, res_x_reg};
            m_tuser_reg <= stale_reg;
        end
    end

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ROT |-> step_reg <= STEP_W'(CORDIC_STEPS - 1))
        else $error("cordic step counter ran past the last iteration");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result shown without a finished rotation");

endmodule

/* hw/rtl/body_to_world_velocity_rotator.sv */
`timescale 1ns / 1ps

// body-to-world velocity rotator for a holonomic base
//
// s_* : input stream, one transfer per item; s_tuser selects the kind
//       (0 = velocity command, 1 = control tick)
//       a command is stored with its time stamp only while enable is set
//       and gives no result; a tick gives exactly one result
// m_* : result stream, world vx/vy rotated by heading plus the midpoint
//       turn correction, the rate (zero when stale) and the stale flag
// cfg_* : plain write port, index 0 = timeout in ms, 1 = enable
//
// the rotator takes a new tick only once it is through with the last one,
// as it is a single iterative cordic stage with a shared gain multiplier
// the front takes a command every cycle unless a tick waits in its first stage,
// which holds s_tready low; a two-entry queue lets the front run ahead of the rotator
// reset clears the stored command to zero, timeout to 500 ms and enable
// to 0; when the receiver stalls the result waits in the output register,
// the rotator holds its finished result, then the queue and front fill
module body_to_world_velocity_rotator #(
    parameter int CORDIC_STEPS = bwvr_pkg::CORDIC_STEPS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration writes
    input  logic                              cfg_wen,
    input  logic [bwvr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bwvr_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input items
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // time_now[31:0], body_vx[47:32], body_vy[63:48], turn_rate[79:64],
    // heading[95:80], period[111:96]
    input  logic [bwvr_pkg::IN_DATA_W-1:0]    s_tdata,
    // mode
    input  logic                              s_tuser,
    // result items
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // world_vx[15:0], world_vy[31:16], rate_out[47:32]
    output logic [bwvr_pkg::OUT_DATA_W-1:0]   m_tdata,
    // stale
    output logic                              m_tuser
);

    // front to queue
    logic           fq_valid, fq_ready;
    bwvr_pkg::job_t fq_job;

    // queue to rotator
    logic           qb_valid, qb_pop;
    bwvr_pkg::job_t qb_job;

    // classification, staleness check and heading correction
    bwvr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .job_valid (fq_valid),
        .job_ready (fq_ready),
        .job       (fq_job)
    );

    // decouples the front from the slow rotator
    bwvr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_job   (fq_job),
        .pop_valid  (qb_valid),
        .pop        (qb_pop),
        .pop_job    (qb_job)
    );

    // iterative cordic rotation, gain correction and output register
    bwvr_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (qb_valid),
        .job_pop   (qb_pop),
        .job       (qb_job),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
